// ===== rtl/core/mpfb_pkg.sv =====
`timescale 1ns / 1ps

package mpfb_pkg;

	localparam int BUF_DEPTH = 1024;
	localparam int ADDR_W    = 10;

	localparam logic [7:0] BYTE_ZERO = 8'h00;
	localparam logic [7:0] BYTE_ONES = 8'hFF;

	typedef enum logic [2:0] {
		OP_PIXEL = 3'd0,
		OP_HLINE = 3'd1,
		OP_VLINE = 3'd2,
		OP_RECT  = 3'd3,
		OP_FILL  = 3'd4,
		OP_READ  = 3'd5
	} opcode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_SEG,
		ST_PIX_RD,
		ST_PIX_WR,
		ST_BYTE_RD,
		ST_BYTE_DATA,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        data;
	} ram_wr_t;

endpackage

// ===== rtl/core/mpfb_if.sv =====
`timescale 1ns / 1ps

interface mpfb_cmd_if;
	import mpfb_pkg::*;

	logic              valid;
	logic              ready;
	logic [2:0]        opcode;
	logic [7:0]        x_start;
	logic [7:0]        x_end;
	logic [7:0]        y_start;
	logic [7:0]        y_end;
	logic              colour;
	logic [ADDR_W-1:0] read_address;

	modport source (
		output valid, opcode, x_start, x_end, y_start, y_end, colour, read_address,
		input  ready
	);
	modport sink (
		input  valid, opcode, x_start, x_end, y_start, y_end, colour, read_address,
		output ready
	);
endinterface

interface mpfb_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] read_data;

	modport source (output valid, read_data, input ready);
	modport sink (input valid, read_data, output ready);
endinterface

// ===== rtl/core/mpfb_page_ram.sv =====
`timescale 1ns / 1ps

module mpfb_page_ram (
	input  logic                      clk,
	input  mpfb_pkg::ram_wr_t         wr,
	input  logic [mpfb_pkg::ADDR_W-1:0] raddr,
	output logic [7:0]                rdata
);
	import mpfb_pkg::*;

	logic [7:0] mem [BUF_DEPTH];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/core/mono_page_framebuffer_draw.sv =====
`timescale 1ns / 1ps

// Page-organized 1-bit frame buffer with a drawing sequencer. Byte x + (y/8)*PANEL_WIDTH
// holds eight vertical pixels, bit y%8. The pixels live in one 1024 x 8 RAM with a write
// port and a registered read port, so every on-panel pixel is a read beat followed by a
// write-back beat, and an off-panel pixel is only a read beat. Each line segment (four
// for a rectangle) has a set-up step, the result is posted on leaving the done state,
// and the next command is taken in the idle state.
// Fill sweeps the RAM one byte per cycle. After reset the same sweep clears the buffer,
// during which no command is taken; invert_colour writes are accepted at any time. The
// result register lets the next command enter while the previous result waits on rsp.
module mono_page_framebuffer_draw #(
	parameter int PANEL_WIDTH  = 128,
	parameter int PANEL_HEIGHT = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	mpfb_cmd_if.sink    cmd,
	mpfb_rsp_if.source  rsp
);
	import mpfb_pkg::*;

	localparam int LIN_RAW = $clog2(PANEL_WIDTH * 32);
	localparam int LIN_W   = (LIN_RAW > ADDR_W) ? LIN_RAW : ADDR_W + 1;

	state_t            state_q, state_d;
	logic              invert_q;
	logic [ADDR_W-1:0] clr_cnt_q;
	logic              fill_val_q;
	logic              from_cmd_q;
	logic              out_valid_q;
	logic [7:0]        out_data_q;

	opcode_t           op_q;
	logic [7:0]        xs_q, xe_q, ys_q, ye_q;
	logic              col_q;
	logic [ADDR_W-1:0] ra_q;
	logic [1:0]        seg_q;
	logic [7:0]        cur_q;
	logic [7:0]        result_q;

	logic              seg_vert, seg_last;
	logic [7:0]        seg_fix, seg_a, seg_b;
	logic [7:0]        px, py;
	logic [LIN_W-1:0]  lin_addr;
	logic              on_panel, seg_done, advance;
	logic [7:0]        mask, rd_data, pix_byte;
	logic [ADDR_W-1:0] ram_raddr;
	ram_wr_t           ram_wr;
	logic              accept;

	assign accept = cmd.valid && cmd.ready;

	// current line segment of the command
	always_comb begin
		seg_vert = 1'b0;
		seg_fix  = ys_q;
		seg_a    = xs_q;
		seg_b    = xe_q;
		seg_last = 1'b1;
		case (op_q)
			OP_PIXEL: seg_b = xs_q;
			OP_HLINE: ;
			OP_VLINE: begin
				seg_vert = 1'b1;
				seg_fix  = xs_q;
				seg_a    = ys_q;
				seg_b    = ye_q;
			end
			OP_RECT: begin
				seg_last = (seg_q == 2'd3);
				case (seg_q)
					2'd0: seg_fix = ys_q;
					2'd1: seg_fix = ye_q;
					2'd2: begin
						seg_vert = 1'b1;
						seg_fix  = xs_q;
						seg_a    = ys_q;
						seg_b    = ye_q;
					end
					default: begin
						seg_vert = 1'b1;
						seg_fix  = xe_q;
						seg_a    = ys_q;
						seg_b    = ye_q;
					end
				endcase
			end
			default: ;
		endcase
	end

	assign px       = seg_vert ? seg_fix : cur_q;
	assign py       = seg_vert ? cur_q : seg_fix;
	assign lin_addr = LIN_W'(px) + LIN_W'(py[7:3]) * LIN_W'(PANEL_WIDTH);
	assign on_panel = ({1'b0, px} < 9'(PANEL_WIDTH)) && ({1'b0, py} < 9'(PANEL_HEIGHT))
			&& (lin_addr < LIN_W'(BUF_DEPTH));
	assign seg_done = (cur_q == seg_b);
	assign advance  = (state_q == ST_PIX_RD && !on_panel) || (state_q == ST_PIX_WR);
	assign mask     = 8'd1 << py[2:0];
	assign pix_byte = col_q ? (rd_data | mask) : (rd_data & ~mask);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd.valid) begin
					case (opcode_t'(cmd.opcode))
						OP_FILL:  state_d = ST_CLEAR;
						OP_READ:  state_d = ST_BYTE_RD;
						OP_PIXEL, OP_HLINE, OP_VLINE, OP_RECT: state_d = ST_SEG;
						default:  state_d = ST_DONE;
					endcase
				end
			end
			ST_CLEAR: begin
				if (&clr_cnt_q) begin
					state_d = from_cmd_q ? ST_DONE : ST_IDLE;
				end
			end
			ST_SEG: begin
				if (seg_a <= seg_b) begin
					state_d = ST_PIX_RD;
				end else if (seg_last) begin
					state_d = ST_DONE;
				end
			end
			ST_PIX_RD, ST_PIX_WR: begin
				if (state_q == ST_PIX_RD && on_panel) begin
					state_d = ST_PIX_WR;
				end else if (!seg_done) begin
					state_d = ST_PIX_RD;
				end else begin
					state_d = seg_last ? ST_DONE : ST_SEG;
				end
			end
			ST_BYTE_RD:   state_d = ST_BYTE_DATA;
			ST_BYTE_DATA: state_d = ST_DONE;
			ST_DONE: begin
				if (!out_valid_q || rsp.ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd.ready    = (state_q == ST_IDLE);
		ram_raddr    = (state_q == ST_BYTE_RD) ? ra_q : lin_addr[ADDR_W-1:0];
		ram_wr.en    = 1'b0;
		ram_wr.addr  = lin_addr[ADDR_W-1:0];
		ram_wr.data  = pix_byte;
		case (state_q)
			ST_CLEAR: begin
				ram_wr.en   = 1'b1;
				ram_wr.addr = clr_cnt_q;
				ram_wr.data = fill_val_q ? BYTE_ONES : BYTE_ZERO;
			end
			ST_PIX_WR: ram_wr.en = 1'b1;
			default: ;
		endcase
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.read_data = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			invert_q    <= 1'b0;
			clr_cnt_q   <= '0;
			fill_val_q  <= 1'b0;
			from_cmd_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				invert_q <= cfg_wdata;
			end
			if (accept) begin
				clr_cnt_q  <= '0;
				fill_val_q <= cmd.colour;
				from_cmd_q <= 1'b1;
			end else if (state_q == ST_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
			if (rsp.valid && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == ST_DONE && state_d == ST_IDLE) begin
				out_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q     <= opcode_t'(cmd.opcode);
			xs_q     <= cmd.x_start;
			xe_q     <= cmd.x_end;
			ys_q     <= cmd.y_start;
			ye_q     <= cmd.y_end;
			col_q    <= cmd.colour ^ invert_q;
			ra_q     <= cmd.read_address;
			seg_q    <= 2'd0;
			result_q <= BYTE_ZERO;
		end
		if (state_q == ST_SEG) begin
			if (seg_a <= seg_b) begin
				cur_q <= seg_a;
			end else begin
				seg_q <= seg_q + 1'b1;
			end
		end
		if (advance) begin
			if (seg_done) begin
				seg_q <= seg_q + 1'b1;
			end else begin
				cur_q <= cur_q + 1'b1;
			end
		end
		if (state_q == ST_BYTE_DATA) begin
			result_q <= rd_data;
		end
		if (state_q == ST_DONE && state_d == ST_IDLE) begin
			out_data_q <= result_q;
		end
	end

	mpfb_page_ram u_ram (
		.clk   (clk),
		.wr    (ram_wr),
		.raddr (ram_raddr),
		.rdata (rd_data)
	);

	a_wr_states: assert property (@(posedge clk) disable iff (!arst_n)
		ram_wr.en |-> (state_q == ST_CLEAR || state_q == ST_PIX_WR))
		else $error("buffer write outside clear or write-back");

	a_wr_after_rd: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_PIX_WR |-> $past(state_q) == ST_PIX_RD)
		else $error("write-back without a read beat");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_DONE)
		else $error("result posted outside completion");

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != ST_IDLE)
		else $error("accepted command did not start");

endmodule
